// ===== rtl/cevq_pkg.sv =====
package cevq_pkg;

   // action codes
   localparam logic [2:0] ACTION_CONNECT    = 3'd0;
   localparam logic [2:0] ACTION_READY      = 3'd1;
   localparam logic [2:0] ACTION_DISCONNECT = 3'd2;
   localparam logic [2:0] ACTION_STORE      = 3'd3;
   localparam logic [2:0] ACTION_READ       = 3'd4;
   localparam logic [2:0] ACTION_DROPPED    = 3'd5;

   // result status codes
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_NO_CONTROLLER = 3'd1;
   localparam logic [2:0] STATUS_NOT_READY     = 3'd2;
   localparam logic [2:0] STATUS_QUEUE_EMPTY   = 3'd3;
   localparam logic [2:0] STATUS_STORED        = 3'd4;
   localparam logic [2:0] STATUS_STORED_DROP   = 3'd5;

   // drop counter saturation value
   localparam logic [15:0] DROP_MAX = 16'hFFFF;

   // one input item
   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  channel;
      logic [7:0]  reason;
      logic [63:0] payload;
   } req_type;

   // one result item
   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] payload_out;
      logic [7:0]  disconnect_reason;
      logic [15:0] dropped_count;
      logic        half_full;
   } rsp_type;

   // result of the control decision, waiting on the word memory
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  disconnect_reason;
      logic [15:0] dropped_count;
      logic        half_full;
      logic        pop;
   } decision_type;

endpackage

// ===== rtl/cevq_mem.sv =====
module cevq_mem #(
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] store_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // single port word store, registered read that holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cevq_ctrl.sv =====
module cevq_ctrl #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int CHANNEL_COUNT = 4,
   localparam int IDX_BITS     = $clog2(QUEUE_DEPTH),
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1),
   localparam int CH_BITS      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  cevq_pkg::req_type             item,
   output cevq_pkg::decision_type        decision,
   output logic                          mem_wr_en,
   output logic                          mem_rd_en,
   output logic [CH_BITS+IDX_BITS-1:0]   mem_addr
);

   logic [IDX_BITS-1:0] head_ff   [CHANNEL_COUNT];
   logic [IDX_BITS-1:0] tail_ff   [CHANNEL_COUNT];
   logic [CNT_BITS-1:0] count_ff  [CHANNEL_COUNT];
   logic [15:0]         drop_ff   [CHANNEL_COUNT];
   logic                conn_ff   [CHANNEL_COUNT];
   logic                rdy_ff    [CHANNEL_COUNT];
   logic [7:0]          reason_ff [CHANNEL_COUNT];
   logic [2:0]          last_ff   [CHANNEL_COUNT];

   logic [IDX_BITS-1:0] head_in;
   logic [IDX_BITS-1:0] tail_in;
   logic [CNT_BITS-1:0] count_in;
   logic [15:0]         drop_in;
   logic                conn_in;
   logic                rdy_in;
   logic [7:0]          reason_in;
   logic [2:0]          last_in;

   logic [CH_BITS-1:0]  ch_idx;
   logic                in_range;
   logic [IDX_BITS-1:0] head_next;
   logic [IDX_BITS-1:0] tail_next;
   logic                ring_full;

   assign ch_idx   = CH_BITS'(item.channel);
   assign in_range = int'(item.channel) < CHANNEL_COUNT;

   // ring pointer increments with wrap at the queue depth
   assign head_next = (head_ff[ch_idx] == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                    : head_ff[ch_idx] + 1'b1;
   assign tail_next = (tail_ff[ch_idx] == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                    : tail_ff[ch_idx] + 1'b1;
   assign ring_full = count_ff[ch_idx] == CNT_BITS'(QUEUE_DEPTH);

   // action decode and next channel state
   always_comb begin
      head_in   = head_ff[ch_idx];
      tail_in   = tail_ff[ch_idx];
      count_in  = count_ff[ch_idx];
      drop_in   = drop_ff[ch_idx];
      conn_in   = conn_ff[ch_idx];
      rdy_in    = rdy_ff[ch_idx];
      reason_in = reason_ff[ch_idx];
      last_in   = last_ff[ch_idx];
      decision  = '0;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      mem_addr  = {ch_idx, tail_ff[ch_idx]};
      if (!in_range) begin
         decision.status = cevq_pkg::STATUS_NO_CONTROLLER;
      end else begin
         case (item.action)
            cevq_pkg::ACTION_CONNECT: begin
               conn_in   = 1'b1;
               reason_in = '0;
            end
            cevq_pkg::ACTION_READY: begin
               rdy_in = 1'b1;
            end
            cevq_pkg::ACTION_DISCONNECT: begin
               conn_in   = 1'b0;
               rdy_in    = 1'b0;
               reason_in = item.reason;
               head_in   = '0;
               tail_in   = '0;
               count_in  = '0;
               drop_in   = '0;
            end
            cevq_pkg::ACTION_STORE: begin
               mem_wr_en = accept;
               tail_in   = tail_next;
               if (ring_full) begin
                  // overwrite oldest word
                  head_in = head_next;
                  if (drop_ff[ch_idx] != cevq_pkg::DROP_MAX) begin
                     drop_in = drop_ff[ch_idx] + 1'b1;
                  end
                  decision.status = cevq_pkg::STATUS_STORED_DROP;
               end else begin
                  count_in        = count_ff[ch_idx] + 1'b1;
                  decision.status = cevq_pkg::STATUS_STORED;
               end
               decision.half_full = count_in >= CNT_BITS'(QUEUE_DEPTH / 2);
            end
            cevq_pkg::ACTION_READ: begin
               if (!conn_ff[ch_idx]) begin
                  decision.status = cevq_pkg::STATUS_NO_CONTROLLER;
                  if (last_ff[ch_idx] != cevq_pkg::STATUS_NO_CONTROLLER) begin
                     decision.disconnect_reason = reason_ff[ch_idx];
                  end
               end else if (!rdy_ff[ch_idx]) begin
                  decision.status = cevq_pkg::STATUS_NOT_READY;
               end else if (count_ff[ch_idx] == '0) begin
                  decision.status = cevq_pkg::STATUS_QUEUE_EMPTY;
               end else begin
                  // pop oldest word
                  mem_rd_en       = accept;
                  mem_addr        = {ch_idx, head_ff[ch_idx]};
                  head_in         = head_next;
                  count_in        = count_ff[ch_idx] - 1'b1;
                  decision.pop    = 1'b1;
                  decision.status = cevq_pkg::STATUS_OK;
               end
               last_in = decision.status;
            end
            cevq_pkg::ACTION_DROPPED: begin
               if (!rdy_ff[ch_idx]) begin
                  decision.status = cevq_pkg::STATUS_NOT_READY;
               end else begin
                  decision.dropped_count = drop_ff[ch_idx];
                  drop_in                = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // per-channel state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            head_ff[i]   <= '0;
            tail_ff[i]   <= '0;
            count_ff[i]  <= '0;
            drop_ff[i]   <= '0;
            conn_ff[i]   <= 1'b0;
            rdy_ff[i]    <= 1'b0;
            reason_ff[i] <= '0;
            last_ff[i]   <= cevq_pkg::STATUS_NOT_READY;
         end
      end else if (accept && in_range) begin
         head_ff[ch_idx]   <= head_in;
         tail_ff[ch_idx]   <= tail_in;
         count_ff[ch_idx]  <= count_in;
         drop_ff[ch_idx]   <= drop_in;
         conn_ff[ch_idx]   <= conn_in;
         rdy_ff[ch_idx]    <= rdy_in;
         reason_ff[ch_idx] <= reason_in;
         last_ff[ch_idx]   <= last_in;
      end
   end

endmodule

// ===== rtl/channel_event_queue_top.sv =====
// Per-channel report queues. Each request names one channel and one action
// (connect, ready, disconnect, store, read, dropped query) and yields exactly
// one response, in order. Requests are taken one per cycle when the response
// side keeps up; a read pops its word from a single-port word memory with a
// registered read while its decision waits in the decision register, and the
// response then passes an output register. A full queue overwrites its oldest
// word and bumps a saturating drop counter. Stored words keep their low
// WORD_BITS bits. Channels at or beyond CHANNEL_COUNT answer no_controller.
// The word memory needs no clearing after reset: only stored words are ever
// read.
module channel_event_queue_top #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int CHANNEL_COUNT = 4,
   parameter int WORD_BITS     = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cevq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cevq_pkg::rsp_type rsp_data
);

   localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CH_BITS   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int ADDR_BITS = CH_BITS + IDX_BITS;

   logic                   accept;
   logic                   advance;
   cevq_pkg::decision_type decision;
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [ADDR_BITS-1:0]   mem_addr;
   logic [WORD_BITS-1:0]   mem_rd_data;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   cevq_pkg::decision_type s1_dec_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   cevq_pkg::rsp_type      rsp_data_ff;

   // handshake: decision stage moves on when the output register is free
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   cevq_ctrl #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_data),
      .decision  (decision),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr)
   );

   // a store and a later pop are accepted at different edges, so no forwarding
   cevq_mem #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (req_data.payload[WORD_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   // control state of the two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // decision stage and output register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dec_ff <= decision;
      end
      if (advance) begin
         rsp_data_ff.status            <= s1_dec_ff.status;
         rsp_data_ff.payload_out       <= s1_dec_ff.pop ? 64'(mem_rd_data) : 64'd0;
         rsp_data_ff.disconnect_reason <= s1_dec_ff.disconnect_reason;
         rsp_data_ff.dropped_count     <= s1_dec_ff.dropped_count;
         rsp_data_ff.half_full         <= s1_dec_ff.half_full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // memory is touched only by a transferred request, never both ways at once
   a_mem_access: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en || mem_rd_en) |-> (accept && !(mem_wr_en && mem_rd_en)))
      else $error("word memory accessed without a transfer");

   // a pop always answers ok
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_dec_ff.pop) |-> (s1_dec_ff.status == cevq_pkg::STATUS_OK))
      else $error("pop with non-ok status");

   // an overwriting store leaves the ring full, hence at least half full
   a_drop_half: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_dec_ff.status == cevq_pkg::STATUS_STORED_DROP)
      |-> s1_dec_ff.half_full)
      else $error("overwriting store without half-full hint");

   // only an ok read carries a word
   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != cevq_pkg::STATUS_OK)
      |-> (rsp_data_ff.payload_out == 64'd0))
      else $error("word on a non-ok response");
`endif

endmodule
